/* src/cfsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsd_pkg
// Shared types and constants for the CAN frame signal decoder.
// ----------------------------------------------------------------------------
package cfsd_pkg;

    localparam int IdW    = 29;
    localparam int LenW   = 4;
    localparam int PayW   = 64;
    localparam int IdxW   = 8;
    localparam int ValW   = 17;
    localparam int CntW   = 4;
    localparam int QDepth = 2;

    // kind of decoding applied to a whole frame
    typedef enum logic [3:0] {
        K_192, K_193, K_482, K_682, K_391, K_392, K_393, K_GPS,
        K_WHEEL, K_TIRE, K_CVOLT, K_CTEMP, K_BRAKE, K_NONE
    } kind_t;

    // classified frame handed from front to back
    typedef struct packed {
        kind_t            kind;
        logic [IdxW-1:0]  base;
        logic [CntW-1:0]  count;
        logic [PayW-1:0]  payload;
    } job_t;

    function automatic logic [7:0] byte_of(input logic [PayW-1:0] p, input logic [2:0] n);
        return p[{n, 3'b000} +: 8];
    endfunction

    function automatic logic [15:0] le16(input logic [PayW-1:0] p, input logic [2:0] n);
        return {byte_of(p, n + 3'd1), byte_of(p, n)};
    endfunction

endpackage

/* src/cfsd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsd_front
// Classifies a frame identifier into decode kind, first index and item count.
// ----------------------------------------------------------------------------
module cfsd_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [cfsd_pkg::IdW-1:0] s_frame_id,
    input  logic [cfsd_pkg::LenW-1:0] s_frame_len,
    input  logic [cfsd_pkg::PayW-1:0] s_frame_payload,
    output logic                     j_valid,
    input  logic                     j_ready,
    output cfsd_pkg::job_t           j_data
);
    import cfsd_pkg::*;

    job_t            q_reg [QDepth];
    logic [0:0]      wr_reg, rd_reg;
    logic [1:0]      cnt_reg;
    job_t            job;
    logic [IdW-1:0]  d;
    logic [4:0]      m;
    logic [1:0]      kd;
    logic            push, pop;

    always_comb begin
        job.kind    = K_NONE;
        job.base    = '0;
        job.count   = '0;
        job.payload = s_frame_payload;
        d  = '0;
        m  = '0;
        kd = '0;
        if (s_frame_id == 29'h192) begin
            job.kind = K_192; job.base = 8'd0; job.count = 4'd5;
        end else if (s_frame_id == 29'h193) begin
            job.kind = K_193; job.base = 8'd5; job.count = 4'd9;
        end else if (s_frame_id == 29'h482) begin
            job.kind = K_482; job.base = 8'd14; job.count = 4'd5;
        end else if (s_frame_id == 29'h682) begin
            job.kind = K_682; job.base = 8'd19; job.count = 4'd5;
        end else if (s_frame_id == 29'h391) begin
            job.kind = K_391; job.base = 8'd24; job.count = 4'd9;
        end else if (s_frame_id == 29'h392) begin
            job.kind = K_392; job.base = 8'd33; job.count = 4'd2;
        end else if (s_frame_id == 29'h393) begin
            job.kind = K_393; job.base = 8'd35; job.count = 4'd1;
        end else if (s_frame_id == 29'hA0001) begin
            job.kind = K_GPS; job.base = 8'd36; job.count = 4'd1;
        end else if (s_frame_id >= 29'h1A5 && s_frame_id <= 29'h1A8) begin
            d = s_frame_id - 29'h1A5;
            job.kind = K_WHEEL; job.base = 8'd37 + {5'd0, d[1:0], 1'b0}; job.count = 4'd2;
        end else if (s_frame_id >= 29'h2A5 && s_frame_id <= 29'h2A8) begin
            d = s_frame_id - 29'h2A5;
            job.kind  = K_TIRE;
            job.base  = 8'd45 + {3'd0, d[1:0], 3'd0};
            job.count = (s_frame_len > 4'd8) ? 4'd8 : s_frame_len;
        end else if (s_frame_id >= 29'h494 && s_frame_id <= 29'h4A2) begin
            d = s_frame_id - 29'h494;
            // small range: divide by three with a short table
            case (d[3:0])
                4'd0, 4'd1, 4'd2:    m = 5'd0;
                4'd3, 4'd4, 4'd5:    m = 5'd6;
                4'd6, 4'd7, 4'd8:    m = 5'd12;
                4'd9, 4'd10, 4'd11:  m = 5'd18;
                default:             m = 5'd24;
            endcase
            kd = 2'(d[3:0] - m[4:1]);
            job.kind  = (kd == 2'd0) ? K_CVOLT : K_CTEMP;
            job.base  = 8'd77 + 8'(kd) * 8'd30 + {3'd0, m};
            job.count = 4'd6;
        end else if (s_frame_id >= 29'h4C4 && s_frame_id <= 29'h4C7) begin
            d = s_frame_id - 29'h4C4;
            job.kind = K_BRAKE; job.base = 8'd167 + {6'd0, d[1:0]}; job.count = 4'd1;
        end
    end

    assign s_ready = (cnt_reg != 2'(QDepth));
    assign push    = s_valid && s_ready && (job.count != '0);
    assign j_valid = (cnt_reg != 2'd0);
    assign pop     = j_valid && j_ready;
    assign j_data  = q_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_reg] <= job;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'(QDepth))
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn) j_valid |-> j_data.count != '0)
        else $error("empty job queued");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");

endmodule

/* src/cfsd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfsd_back
// Walks a classified frame and emits one decoded signal per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module cfsd_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        j_valid,
    output logic                        j_ready,
    input  cfsd_pkg::job_t              j_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cfsd_pkg::IdxW-1:0]   m_signal_index,
    output logic signed [cfsd_pkg::ValW-1:0] m_signal_value,
    output logic                        m_last_signal
);
    import cfsd_pkg::*;

    logic [CntW-1:0]        step_reg;
    logic                   ov_reg;
    logic [IdxW-1:0]        oi_reg;
    logic signed [ValW-1:0] ovl_reg;
    logic                   ol_reg;
    logic                   load;
    logic [7:0]             b0, b1, bs;
    logic [15:0]            w;
    logic [9:0]             soc;
    logic [16:0]            val;
    logic                   last;

    assign b0  = byte_of(j_data.payload, 3'd0);
    assign b1  = byte_of(j_data.payload, 3'd1);
    assign bs  = byte_of(j_data.payload, step_reg[2:0]);
    assign soc = {j_data.payload[59:56], j_data.payload[55:50]};
    assign last = (step_reg + 1'b1 == j_data.count);

    // per-step value selection; divides by ten are small-width reciprocal multiplies
    always_comb begin
        val = '0;
        w   = '0;
        case (j_data.kind)
            K_192: begin
                case (step_reg)
                    4'd0:    val = 17'(byte_of(j_data.payload, 3'd4));
                    4'd1:    val = 17'(byte_of(j_data.payload, 3'd7));
                    4'd2:    val = 17'(le16(j_data.payload, 3'd0));
                    4'd3:    val = 17'(le16(j_data.payload, 3'd2));
                    default: val = 17'(le16(j_data.payload, 3'd4));
                endcase
            end
            K_193: begin
                case (step_reg)
                    4'd0:    val = 17'(le16(j_data.payload, 3'd2));
                    4'd1:    val = 17'(le16(j_data.payload, 3'd4));
                    4'd2:    val = 17'(b0[0]);
                    4'd3:    val = 17'(b0[3]);
                    4'd4:    val = 17'(b0[4]);
                    4'd5:    val = 17'(b0[5]);
                    4'd6:    val = 17'(b0[6]);
                    4'd7:    val = 17'(b0[7]);
                    default: val = 17'(b1[0]);
                endcase
            end
            K_482: begin
                case (step_reg)
                    4'd0:    val = 17'(le16(j_data.payload, 3'd0));
                    4'd1:    val = 17'(j_data.payload[38]);
                    4'd2:    val = 17'(j_data.payload[41]);
                    4'd3:    val = 17'(j_data.payload[44]);
                    default: val = 17'(j_data.payload[45]);
                endcase
            end
            K_682: begin
                case (step_reg)
                    4'd0:    val = (b0 >= 8'd40) ? 17'(b0 - 8'd40) : '0;
                    4'd1:    val = (b1 >= 8'd40) ? 17'(b1 - 8'd40) : '0;
                    4'd2:    val = 17'(le16(j_data.payload, 3'd2));
                    4'd3:    val = 17'(byte_of(j_data.payload, 3'd4));
                    default: val = 17'(byte_of(j_data.payload, 3'd5));
                endcase
            end
            K_391: begin
                case (step_reg)
                    4'd0:    val = 17'(b0[0]);
                    4'd1:    val = 17'(b0[1]);
                    4'd2:    val = 17'(b0[2]);
                    4'd3:    val = 17'(b0[4]);
                    4'd4:    val = 17'(b0[5]);
                    4'd5:    val = 17'(b0[6]);
                    4'd6:    val = 17'(b0[7]);
                    4'd7:    val = 17'(byte_of(j_data.payload, 3'd4));
                    default: val = 17'(le16(j_data.payload, 3'd5));
                endcase
            end
            K_392: begin
                if (step_reg == 4'd0) val = 17'(le16(j_data.payload, 3'd0));
                else                  val = 17'((22'(soc) * 22'd205) >> 11);
            end
            K_393:   val = 17'(b1[7:2]);
            K_GPS:   val = 17'({b0, b1});
            K_WHEEL: begin
                w = le16(j_data.payload, 3'd0);
                if (step_reg == 4'd0) val = 17'(byte_of(j_data.payload, 3'd6));
                else if (w[15])       val = '0;
                else                  val = 17'(8'((32'(w) * 32'd52429) >> 19));
            end
            K_TIRE:  val = 17'(bs);
            K_CVOLT: val = 17'(bs);
            K_CTEMP: val = 17'(bs[7:2]);
            K_BRAKE: val = 17'({b0, b1}) - 17'd1000;
            default: val = '0;
        endcase
    end

    assign load    = j_valid && (!ov_reg || m_ready);
    assign j_ready = load && last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            ov_reg   <= 1'b0;
        end else begin
            if (load) begin
                ov_reg   <= 1'b1;
                step_reg <= last ? '0 : step_reg + 1'b1;
            end else if (m_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            oi_reg  <= j_data.base + 8'(step_reg);
            ovl_reg <= val;
            ol_reg  <= last;
        end
    end

    assign m_valid        = ov_reg;
    assign m_signal_index = oi_reg;
    assign m_signal_value = ovl_reg;
    assign m_last_signal  = ol_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        j_valid |-> step_reg < j_data.count)
        else $error("step past item count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        j_ready |=> m_valid && m_last_signal)
        else $error("last signal not flagged");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped");

endmodule

/* src/can_frame_signal_decoder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_signal_decoder_unit
// Decodes received CAN frames into indexed signal writes.
// ----------------------------------------------------------------------------
// a frame is registered in the job queue on acceptance, and each signal is registered in the output stage
// one signal per cycle while m_ready is high; a frame yields as many signals as its item count (1 to 9)
// a two-entry job queue lets frames be taken while the output stage walks a frame
// unknown identifiers are accepted and produce nothing
// reset: synchronous active low, clears queue and output valid
module can_frame_signal_decoder_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [cfsd_pkg::IdW-1:0]    s_frame_id,
    input  logic [cfsd_pkg::LenW-1:0]   s_frame_len,
    input  logic [cfsd_pkg::PayW-1:0]   s_frame_payload,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cfsd_pkg::IdxW-1:0]   m_signal_index,
    output logic signed [cfsd_pkg::ValW-1:0] m_signal_value,
    output logic                        m_last_signal
);
    import cfsd_pkg::*;

    logic j_valid, j_ready;
    job_t j_data;

    cfsd_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_frame_id, .s_frame_len, .s_frame_payload,
        .j_valid, .j_ready, .j_data
    );

    cfsd_back u_back (
        .aclk, .aresetn, .j_valid, .j_ready, .j_data,
        .m_valid, .m_ready, .m_signal_index, .m_signal_value, .m_last_signal
    );

endmodule
